### design/mlfq_pkg.sv
package mlfq_pkg;

    localparam int NumLevelsDef  = 4;
    localparam int MaxThreadsDef = 32;
    localparam int QuantumMax    = 32767;

    typedef enum logic [1:0] {
        ST_WAITING,
        ST_READY,
        ST_RUNNING,
        ST_DEAD
    } t_tstate;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_ADMIT,
        OP_SET_STATE,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        RES_OK,
        RES_IDLE,
        RES_NO_READY
    } t_res;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_SET_STATE,
        CMD_ADMIT,
        CMD_TICK,
        CMD_RELEVEL,
        CMD_SPLICE,
        CMD_USE_RUN,
        CMD_DEC_SLICE,
        CMD_EXPIRE,
        CMD_REQUEUE,
        CMD_UNL_START,
        CMD_STEP,
        CMD_DROP,
        CMD_CLR_QUEUED,
        CMD_APPEND,
        CMD_PICK_START,
        CMD_NEXT_LVL,
        CMD_TAKE,
        CMD_CLR_RUN,
        CMD_SELECT,
        CMD_RESULT
    } t_cmd;

    typedef struct packed {
        t_cmd op;
        t_res code;
    } t_cmd_bus;

    typedef struct packed {
        t_op     op;
        logic    id_ok;
        logic    boost_due;
        logic    run_valid;
        t_tstate run_state;
        logic    slice_gt1;
        logic    tgt_queued;
        logic    walk_end;
        logic    walk_hit;
        logic    cur_ready;
        logic    lvl_last;
        logic    out_free;
    } t_status;

    function automatic logic [14:0] quantum(input logic [11:0] base, input logic [2:0] lvl);
        logic [19:0] q;
        q = 20'(base) << lvl;
        return (q > 20'(QuantumMax)) ? 15'(QuantumMax) : q[14:0];
    endfunction

endpackage

### design/mlfq_ctrl.sv
module mlfq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mlfq_pkg::t_status i_status,
    output logic              o_in_stall,
    output mlfq_pkg::t_cmd_bus o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RELEVEL,
        S_SPLICE,
        S_TICK_SEL,
        S_ENQ,
        S_UNL_WALK,
        S_APPEND,
        S_PICK_START,
        S_PICK,
        S_SELECT,
        S_DONE
    } t_fsm;

    typedef enum logic [1:0] {
        AFT_DONE,
        AFT_PICK,
        AFT_UNL_PICK
    } t_after;

    t_fsm          r_fsm;
    t_after        r_after;
    logic          r_first;
    mlfq_pkg::t_res r_code;

    assign o_in_stall = (r_fsm != S_IDLE);

    always_comb begin
        o_cmd.op   = mlfq_pkg::CMD_NONE;
        o_cmd.code = r_code;
        unique case (r_fsm)
            S_IDLE: begin
                if (i_in_valid) o_cmd.op = mlfq_pkg::CMD_LATCH;
            end
            S_DISPATCH: begin
                unique case (i_status.op)
                    mlfq_pkg::OP_TICK: o_cmd.op = mlfq_pkg::CMD_TICK;
                    mlfq_pkg::OP_ADMIT: begin
                        if (i_status.id_ok) o_cmd.op = mlfq_pkg::CMD_ADMIT;
                    end
                    mlfq_pkg::OP_SET_STATE: begin
                        if (i_status.id_ok) o_cmd.op = mlfq_pkg::CMD_SET_STATE;
                    end
                    mlfq_pkg::OP_NOP: o_cmd.op = mlfq_pkg::CMD_NONE;
                endcase
            end
            S_RELEVEL: o_cmd.op = mlfq_pkg::CMD_RELEVEL;
            S_SPLICE: o_cmd.op = mlfq_pkg::CMD_SPLICE;
            S_TICK_SEL: begin
                if (i_status.run_valid) begin
                    unique case (i_status.run_state)
                        mlfq_pkg::ST_READY: o_cmd.op = mlfq_pkg::CMD_USE_RUN;
                        mlfq_pkg::ST_RUNNING: begin
                            o_cmd.op = i_status.slice_gt1 ? mlfq_pkg::CMD_DEC_SLICE
                                                          : mlfq_pkg::CMD_EXPIRE;
                        end
                        mlfq_pkg::ST_WAITING: o_cmd.op = mlfq_pkg::CMD_REQUEUE;
                        mlfq_pkg::ST_DEAD: o_cmd.op = mlfq_pkg::CMD_REQUEUE;
                    endcase
                end else begin
                    o_cmd.op = mlfq_pkg::CMD_PICK_START;
                end
            end
            S_ENQ: begin
                if (i_status.tgt_queued) o_cmd.op = mlfq_pkg::CMD_UNL_START;
            end
            S_UNL_WALK: begin
                priority if (i_status.walk_end) o_cmd.op = mlfq_pkg::CMD_CLR_QUEUED;
                else if (i_status.walk_hit) o_cmd.op = mlfq_pkg::CMD_DROP;
                else o_cmd.op = mlfq_pkg::CMD_STEP;
            end
            S_APPEND: o_cmd.op = mlfq_pkg::CMD_APPEND;
            S_PICK_START: o_cmd.op = mlfq_pkg::CMD_PICK_START;
            S_PICK: begin
                priority if (!i_status.walk_end) begin
                    o_cmd.op = i_status.cur_ready ? mlfq_pkg::CMD_TAKE : mlfq_pkg::CMD_STEP;
                end else if (!i_status.lvl_last) begin
                    o_cmd.op = mlfq_pkg::CMD_NEXT_LVL;
                end else if (!r_first) begin
                    o_cmd.op = mlfq_pkg::CMD_CLR_RUN;
                end
            end
            S_SELECT: o_cmd.op = mlfq_pkg::CMD_SELECT;
            S_DONE: begin
                if (i_status.out_free) o_cmd.op = mlfq_pkg::CMD_RESULT;
            end
            default: o_cmd.op = mlfq_pkg::CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= S_IDLE;
            r_after <= AFT_DONE;
            r_first <= 1'b0;
            r_code  <= mlfq_pkg::RES_OK;
        end else begin
            unique case (r_fsm)
                S_IDLE: begin
                    if (i_in_valid) r_fsm <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    r_code <= mlfq_pkg::RES_OK;
                    unique case (i_status.op)
                        mlfq_pkg::OP_TICK: begin
                            r_fsm <= i_status.boost_due ? S_RELEVEL : S_TICK_SEL;
                        end
                        mlfq_pkg::OP_ADMIT: begin
                            r_after <= AFT_DONE;
                            r_fsm   <= i_status.id_ok ? S_ENQ : S_DONE;
                        end
                        mlfq_pkg::OP_SET_STATE: r_fsm <= S_DONE;
                        mlfq_pkg::OP_NOP: r_fsm <= S_DONE;
                    endcase
                end
                S_RELEVEL: r_fsm <= S_SPLICE;
                S_SPLICE: begin
                    if (i_status.lvl_last) r_fsm <= S_TICK_SEL;
                end
                S_TICK_SEL: begin
                    if (i_status.run_valid) begin
                        r_first <= 1'b0;
                        unique case (i_status.run_state)
                            mlfq_pkg::ST_READY: r_fsm <= S_SELECT;
                            mlfq_pkg::ST_RUNNING: begin
                                if (i_status.slice_gt1) begin
                                    r_fsm <= S_DONE;
                                end else begin
                                    r_after <= AFT_PICK;
                                    r_fsm   <= S_ENQ;
                                end
                            end
                            mlfq_pkg::ST_WAITING: begin
                                r_after <= AFT_PICK;
                                r_fsm   <= S_ENQ;
                            end
                            mlfq_pkg::ST_DEAD: begin
                                r_after <= AFT_UNL_PICK;
                                r_fsm   <= S_ENQ;
                            end
                        endcase
                    end else begin
                        r_first <= 1'b1;
                        r_fsm   <= S_PICK;
                    end
                end
                S_ENQ: begin
                    priority if (i_status.tgt_queued) r_fsm <= S_UNL_WALK;
                    else if (r_after == AFT_UNL_PICK) r_fsm <= S_PICK_START;
                    else r_fsm <= S_APPEND;
                end
                S_UNL_WALK: begin
                    if (i_status.walk_end || i_status.walk_hit) begin
                        r_fsm <= (r_after == AFT_UNL_PICK) ? S_PICK_START : S_APPEND;
                    end
                end
                S_APPEND: r_fsm <= (r_after == AFT_DONE) ? S_DONE : S_PICK_START;
                S_PICK_START: r_fsm <= S_PICK;
                S_PICK: begin
                    if (!i_status.walk_end) begin
                        if (i_status.cur_ready) r_fsm <= S_SELECT;
                    end else if (i_status.lvl_last) begin
                        r_code <= r_first ? mlfq_pkg::RES_IDLE : mlfq_pkg::RES_NO_READY;
                        r_fsm  <= S_DONE;
                    end
                end
                S_SELECT: r_fsm <= S_DONE;
                S_DONE: begin
                    if (i_status.out_free) r_fsm <= S_IDLE;
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

endmodule

### design/mlfq_dp.sv
module mlfq_dp #(
    parameter int NUM_LEVELS  = mlfq_pkg::NumLevelsDef,
    parameter int MAX_THREADS = mlfq_pkg::MaxThreadsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mlfq_pkg::t_cmd_bus i_cmd,
    input  logic [1:0]         i_operation,
    input  logic [4:0]         i_thread_id,
    input  logic [1:0]         i_level,
    input  logic [1:0]         i_new_state,
    input  logic [11:0]        i_base_quantum,
    input  logic [15:0]        i_boost_interval,
    input  logic               i_out_stall,
    output mlfq_pkg::t_status  o_status,
    output logic               o_out_valid,
    output logic               o_has_current,
    output logic [4:0]         o_current_thread,
    output logic [1:0]         o_current_level,
    output logic [1:0]         o_result
);

    localparam int LW = $clog2(NUM_LEVELS);
    localparam int TW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);

    mlfq_pkg::t_op     r_op;
    logic [4:0]        r_id;
    logic [1:0]        r_lvl_in;
    mlfq_pkg::t_tstate r_nst;

    mlfq_pkg::t_tstate r_tstate [MAX_THREADS];
    logic [LW-1:0]     r_level  [MAX_THREADS];
    logic [14:0]       r_slice  [MAX_THREADS];
    logic [TW-1:0]     r_link   [MAX_THREADS];
    logic              r_queued [MAX_THREADS];
    logic [TW-1:0]     r_head   [NUM_LEVELS];
    logic [TW-1:0]     r_tail   [NUM_LEVELS];
    logic [CW-1:0]     r_count  [NUM_LEVELS];

    logic [15:0]   r_ticks;
    logic [TW-1:0] r_run_slot;
    logic          r_run_valid;
    logic [TW-1:0] r_tslot;
    logic [LW-1:0] r_elvl;
    logic [LW-1:0] r_w_lvl;
    logic [TW-1:0] r_w_cur;
    logic [TW-1:0] r_w_prev;
    logic          r_w_prev_none;
    logic [CW-1:0] r_w_k;
    logic [TW-1:0] r_pick;

    logic       r_out_valid;
    logic       r_has;
    logic [4:0] r_thread;
    logic [1:0] r_olvl;
    logic [1:0] r_code;

    logic [15:0]   n_ticks;
    logic [TW-1:0] id_slot;
    logic [LW-1:0] admit_lvl;
    logic [LW-1:0] demote_lvl;
    logic [LW-1:0] next_lvl;
    logic          drop_has_next;
    logic [TW-1:0] drop_next;

    assign n_ticks    = r_ticks + 16'd1;
    assign id_slot    = TW'(r_id);
    assign admit_lvl  = (32'(r_lvl_in) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1) : LW'(r_lvl_in);
    assign demote_lvl = (32'(r_level[r_run_slot]) + 1 >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1)
                                                                      : r_level[r_run_slot] + 1'b1;
    assign next_lvl   = r_w_lvl + 1'b1;
    assign drop_has_next = (r_count[r_w_lvl] > CW'(1)) && (r_tail[r_w_lvl] != r_w_cur);
    assign drop_next     = r_link[r_w_cur];

    always_comb begin
        o_status.op         = r_op;
        o_status.id_ok      = (32'(r_id) < MAX_THREADS);
        o_status.boost_due  = (n_ticks >= i_boost_interval);
        o_status.run_valid  = r_run_valid;
        o_status.run_state  = r_tstate[r_run_slot];
        o_status.slice_gt1  = (r_slice[r_run_slot] > 15'd1);
        o_status.tgt_queued = r_queued[r_tslot];
        o_status.walk_end   = (r_w_k >= r_count[r_w_lvl]);
        o_status.walk_hit   = (r_w_cur == r_tslot);
        o_status.cur_ready  = (r_tstate[r_w_cur] == mlfq_pkg::ST_READY);
        o_status.lvl_last   = (r_w_lvl == LW'(NUM_LEVELS - 1));
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid      = r_out_valid;
    assign o_has_current    = r_has;
    assign o_current_thread = r_thread;
    assign o_current_level  = r_olvl;
    assign o_result         = r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_THREADS; i++) begin
                r_tstate[i] <= mlfq_pkg::ST_WAITING;
                r_level[i]  <= '0;
                r_slice[i]  <= '0;
                r_queued[i] <= 1'b0;
            end
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_count[l] <= '0;
            end
            r_ticks     <= '0;
            r_run_slot  <= '0;
            r_run_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            unique case (i_cmd.op)
                mlfq_pkg::CMD_LATCH: begin
                    r_op     <= mlfq_pkg::t_op'(i_operation);
                    r_id     <= i_thread_id;
                    r_lvl_in <= i_level;
                    r_nst    <= mlfq_pkg::t_tstate'(i_new_state);
                end
                mlfq_pkg::CMD_SET_STATE: r_tstate[id_slot] <= r_nst;
                mlfq_pkg::CMD_ADMIT: begin
                    if (r_run_valid && r_run_slot == id_slot) begin
                        r_run_valid <= 1'b0;
                        r_run_slot  <= '0;
                    end
                    r_tstate[id_slot] <= r_nst;
                    r_tslot <= id_slot;
                    r_elvl  <= admit_lvl;
                end
                mlfq_pkg::CMD_TICK: begin
                    r_ticks <= o_status.boost_due ? 16'd0 : n_ticks;
                end
                mlfq_pkg::CMD_RELEVEL: begin
                    for (int i = 0; i < MAX_THREADS; i++) begin
                        if (r_queued[i]) r_level[i] <= '0;
                    end
                    r_w_lvl <= LW'(1);
                end
                mlfq_pkg::CMD_SPLICE: begin
                    if (r_count[r_w_lvl] != '0) begin
                        if (r_count[0] == '0) r_head[0] <= r_head[r_w_lvl];
                        else r_link[r_tail[0]] <= r_head[r_w_lvl];
                        r_tail[0]        <= r_tail[r_w_lvl];
                        r_count[0]       <= r_count[0] + r_count[r_w_lvl];
                        r_count[r_w_lvl] <= '0;
                    end
                    r_w_lvl <= next_lvl;
                end
                mlfq_pkg::CMD_USE_RUN: r_pick <= r_run_slot;
                mlfq_pkg::CMD_DEC_SLICE: r_slice[r_run_slot] <= r_slice[r_run_slot] - 15'd1;
                mlfq_pkg::CMD_EXPIRE: begin
                    r_slice[r_run_slot]  <= '0;
                    r_tstate[r_run_slot] <= mlfq_pkg::ST_READY;
                    r_tslot <= r_run_slot;
                    r_elvl  <= demote_lvl;
                end
                mlfq_pkg::CMD_REQUEUE: begin
                    r_tslot <= r_run_slot;
                    r_elvl  <= demote_lvl;
                end
                mlfq_pkg::CMD_UNL_START: begin
                    r_w_lvl       <= r_level[r_tslot];
                    r_w_cur       <= r_head[r_level[r_tslot]];
                    r_w_prev_none <= 1'b1;
                    r_w_k         <= '0;
                end
                mlfq_pkg::CMD_STEP: begin
                    r_w_prev      <= r_w_cur;
                    r_w_prev_none <= 1'b0;
                    r_w_cur       <= r_link[r_w_cur];
                    r_w_k         <= r_w_k + 1'b1;
                end
                mlfq_pkg::CMD_DROP, mlfq_pkg::CMD_TAKE: begin
                    if (drop_has_next) begin
                        if (r_w_prev_none) r_head[r_w_lvl] <= drop_next;
                        else r_link[r_w_prev] <= drop_next;
                    end
                    if (r_tail[r_w_lvl] == r_w_cur && !r_w_prev_none) begin
                        r_tail[r_w_lvl] <= r_w_prev;
                    end
                    r_count[r_w_lvl]  <= r_count[r_w_lvl] - 1'b1;
                    r_queued[r_w_cur] <= 1'b0;
                    if (i_cmd.op == mlfq_pkg::CMD_TAKE) begin
                        r_slice[r_w_cur] <= mlfq_pkg::quantum(i_base_quantum, 3'(r_w_lvl));
                        r_pick           <= r_w_cur;
                    end
                end
                mlfq_pkg::CMD_CLR_QUEUED: r_queued[r_tslot] <= 1'b0;
                mlfq_pkg::CMD_APPEND: begin
                    r_level[r_tslot]  <= r_elvl;
                    r_queued[r_tslot] <= 1'b1;
                    if (r_count[r_elvl] == '0) r_head[r_elvl] <= r_tslot;
                    else r_link[r_tail[r_elvl]] <= r_tslot;
                    r_tail[r_elvl]  <= r_tslot;
                    r_count[r_elvl] <= r_count[r_elvl] + 1'b1;
                end
                mlfq_pkg::CMD_PICK_START: begin
                    r_w_lvl       <= '0;
                    r_w_cur       <= r_head[0];
                    r_w_prev_none <= 1'b1;
                    r_w_k         <= '0;
                end
                mlfq_pkg::CMD_NEXT_LVL: begin
                    r_w_lvl       <= next_lvl;
                    r_w_cur       <= r_head[next_lvl];
                    r_w_prev_none <= 1'b1;
                    r_w_k         <= '0;
                end
                mlfq_pkg::CMD_CLR_RUN: begin
                    r_run_valid <= 1'b0;
                    r_run_slot  <= '0;
                end
                mlfq_pkg::CMD_SELECT: begin
                    r_run_slot       <= r_pick;
                    r_run_valid      <= 1'b1;
                    r_tstate[r_pick] <= mlfq_pkg::ST_RUNNING;
                end
                mlfq_pkg::CMD_RESULT: begin
                    r_out_valid <= 1'b1;
                    r_has       <= r_run_valid;
                    r_thread    <= r_run_valid ? 5'(r_run_slot) : 5'd0;
                    r_olvl      <= r_run_valid ? 2'(r_level[r_run_slot]) : 2'd0;
                    r_code      <= i_cmd.code;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### design/mlfq_thread_scheduler.sv
// An admit of a queued slot walks its level list to unlink the entry, and a tick that picks
// a thread walks the level lists from level 0 for a ready entry.
// Items are handled one at a time: the input stalls from acceptance until the result is
// registered, and the single list walker serves every walk.
// A finished result waits in an output register while the next transfer is accepted.
// Reset is synchronous and active low; it clears thread states, levels, slices, queue flags,
// counts and the running selection and loads base_quantum 10 and boost_interval 100.
module mlfq_thread_scheduler #(
    parameter int NUM_LEVELS  = mlfq_pkg::NumLevelsDef,
    parameter int MAX_THREADS = mlfq_pkg::MaxThreadsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [4:0]  i_thread_id,
    input  logic [1:0]  i_level,
    input  logic [1:0]  i_new_state,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_has_current,
    output logic [4:0]  o_current_thread,
    output logic [1:0]  o_current_level,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [11:0] r_base_quantum;
    logic [15:0] r_boost_interval;

    mlfq_pkg::t_cmd_bus cmd;
    mlfq_pkg::t_status  status;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'(r_boost_interval) : 32'(r_base_quantum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_quantum   <= 12'd10;
            r_boost_interval <= 16'd100;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_boost_interval <= pwdata[15:0];
            else r_base_quantum <= pwdata[11:0];
        end
    end

    mlfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    mlfq_dp #(
        .NUM_LEVELS  (NUM_LEVELS),
        .MAX_THREADS (MAX_THREADS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_operation      (i_operation),
        .i_thread_id      (i_thread_id),
        .i_level          (i_level),
        .i_new_state      (i_new_state),
        .i_base_quantum   (r_base_quantum),
        .i_boost_interval (r_boost_interval),
        .i_out_stall      (i_out_stall),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .o_has_current    (o_has_current),
        .o_current_thread (o_current_thread),
        .o_current_level  (o_current_level),
        .o_result         (o_status)
    );

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_current) |-> (o_current_thread == 5'd0 && o_current_level == 2'd0))
        else $error("result without a thread carries a nonzero slot or level");

    a_fail_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != mlfq_pkg::RES_OK) |-> !o_has_current)
        else $error("failed tick still reports a running thread");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("scheduler took no busy cycle after an input transfer");

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int NLV = 4;
    localparam int NTH = 32;
    localparam int NONE = 255;
    localparam logic [2:0] ADDR_BASE_Q = 3'd0;
    localparam logic [2:0] ADDR_BOOST  = 3'd4;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic       has_cur;
        logic [4:0] cur_thread;
        logic [1:0] cur_level;
        logic [1:0] status;
    } t_sched_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_operation = '0;
    logic [4:0]  i_thread_id = '0;
    logic [1:0]  i_level = '0;
    logic [1:0]  i_new_state = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_has_current;
    logic [4:0]  o_current_thread;
    logic [1:0]  o_current_level;
    logic [1:0]  o_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mlfq_thread_scheduler dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Scheduler shadow state.
    int unsigned       qbase;
    int unsigned       qboost;
    mlfq_pkg::t_tstate th_state [NTH];
    int unsigned       th_level [NTH];
    int unsigned       th_slice [NTH];
    int unsigned       lvl_q [NLV][$];
    int unsigned       boost_cnt;
    int unsigned       run_slot;
    bit                run_valid;

    t_sched_out  sched_expected [$];
    int          errors = 0;
    int          results_seen = 0;
    int          cycles = 0;
    bit          stall_hold = 1'b0;
    bit          rx_idle_en = 1'b1;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
        errors++;
    endtask

    function automatic void unqueue(int unsigned slot);
        int unsigned lv;
        lv = th_level[slot];
        for (int k = 0; k < lvl_q[lv].size(); k++) begin
            if (lvl_q[lv][k] == slot) begin
                lvl_q[lv].delete(k);
                return;
            end
        end
    endfunction

    function automatic bit is_queued(int unsigned slot);
        int unsigned lv;
        lv = th_level[slot];
        for (int k = 0; k < lvl_q[lv].size(); k++)
            if (lvl_q[lv][k] == slot) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void enqueue(int unsigned slot, int unsigned lv);
        if (lv >= NLV) lv = NLV - 1;
        if (is_queued(slot)) unqueue(slot);
        th_level[slot] = lv;
        lvl_q[lv].push_back(slot);
    endfunction

    function automatic int unsigned slice_for(int unsigned lv);
        int unsigned q;
        q = qbase << lv;
        return (q > mlfq_pkg::QuantumMax) ? mlfq_pkg::QuantumMax : q;
    endfunction

    function automatic int unsigned pick_ready();
        int unsigned s;
        for (int lv = 0; lv < NLV; lv++) begin
            for (int k = 0; k < lvl_q[lv].size(); k++) begin
                s = lvl_q[lv][k];
                if (th_state[s] == mlfq_pkg::ST_READY) begin
                    lvl_q[lv].delete(k);
                    th_slice[s] = slice_for(lv);
                    return s;
                end
            end
        end
        return NONE;
    endfunction

    function automatic mlfq_pkg::t_res sched_tick();
        int unsigned cur;
        int unsigned nxt;
        boost_cnt = (boost_cnt + 1) & 16'hFFFF;
        if (boost_cnt >= qboost) begin
            for (int lv = 1; lv < NLV; lv++) begin
                for (int k = 0; k < lvl_q[lv].size(); k++) begin
                    th_level[lvl_q[lv][k]] = 0;
                    lvl_q[0].push_back(lvl_q[lv][k]);
                end
                lvl_q[lv].delete();
            end
            boost_cnt = 0;
        end
        if (run_valid) cur = run_slot;
        else begin
            cur = pick_ready();
            if (cur == NONE) return mlfq_pkg::RES_IDLE;
        end
        case (th_state[cur])
            mlfq_pkg::ST_READY: nxt = cur;
            mlfq_pkg::ST_RUNNING: begin
                if (th_slice[cur] > 1) begin
                    th_slice[cur]--;
                    run_slot = cur;
                    run_valid = 1'b1;
                    return mlfq_pkg::RES_OK;
                end
                th_slice[cur] = 0;
                th_state[cur] = mlfq_pkg::ST_READY;
                enqueue(cur, th_level[cur] + 1);
                nxt = pick_ready();
            end
            mlfq_pkg::ST_WAITING: begin
                enqueue(cur, th_level[cur] + 1);
                nxt = pick_ready();
            end
            default: begin
                if (is_queued(cur)) unqueue(cur);
                nxt = pick_ready();
            end
        endcase
        if (nxt == NONE) begin
            run_valid = 1'b0;
            run_slot = 0;
            return mlfq_pkg::RES_NO_READY;
        end
        run_slot = nxt;
        run_valid = 1'b1;
        th_state[nxt] = mlfq_pkg::ST_RUNNING;
        return mlfq_pkg::RES_OK;
    endfunction

    function automatic t_sched_out sched_step(mlfq_pkg::t_op op, int unsigned slot,
                                              int unsigned lv, mlfq_pkg::t_tstate nst);
        t_sched_out r;
        mlfq_pkg::t_res st;
        st = mlfq_pkg::RES_OK;
        case (op)
            mlfq_pkg::OP_TICK: st = sched_tick();
            mlfq_pkg::OP_ADMIT: begin
                if (run_valid && run_slot == slot) begin
                    run_valid = 1'b0;
                    run_slot = 0;
                end
                th_state[slot] = nst;
                enqueue(slot, lv);
            end
            mlfq_pkg::OP_SET_STATE: th_state[slot] = nst;
            default: ;
        endcase
        r.has_cur    = run_valid;
        r.cur_thread = run_valid ? 5'(run_slot) : '0;
        r.cur_level  = run_valid ? 2'(th_level[run_slot]) : '0;
        r.status     = st;
        return r;
    endfunction

    task automatic shadow_reset();
        qbase = 10;
        qboost = 100;
        for (int i = 0; i < NTH; i++) begin
            th_state[i] = mlfq_pkg::ST_WAITING;
            th_level[i] = 0;
            th_slice[i] = 0;
        end
        for (int lv = 0; lv < NLV; lv++) lvl_q[lv].delete();
        boost_cnt = 0;
        run_slot = 0;
        run_valid = 1'b0;
    endtask

    task automatic send_item(mlfq_pkg::t_op op, int unsigned slot, int unsigned lv,
                             mlfq_pkg::t_tstate nst, bit gaps = 1'b1);
        int gap;
        gap = 0;
        if (gaps) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) gap = 0;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_thread_id <= 5'(slot);
        i_level     <= 2'(lv);
        i_new_state <= nst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sched_expected.push_back(sched_step(op, slot, lv, nst));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sched_expected.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(int unsigned bq, int unsigned bi);
        wait_drained();
        apb_write(ADDR_BASE_Q, 32'(bq));
        apb_write(ADDR_BOOST, 32'(bi));
        qbase = bq;
        qboost = bi;
    endtask

    task automatic random_item(int tick_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < tick_pct)
            send_item(mlfq_pkg::OP_TICK, $urandom_range(0, 31), $urandom_range(0, 3),
                      mlfq_pkg::t_tstate'($urandom_range(0, 3)));
        else if (r < tick_pct + (100 - tick_pct) / 2)
            send_item(mlfq_pkg::OP_ADMIT, $urandom_range(0, 31), $urandom_range(0, 3),
                      ($urandom_range(0, 3) != 0) ? mlfq_pkg::ST_READY
                                                  : mlfq_pkg::t_tstate'($urandom_range(0, 3)));
        else if (r < 97)
            send_item(mlfq_pkg::OP_SET_STATE, $urandom_range(0, 31), $urandom_range(0, 3),
                      mlfq_pkg::t_tstate'($urandom_range(0, 3)));
        else
            send_item(mlfq_pkg::OP_NOP, $urandom_range(0, 31), $urandom_range(0, 3),
                      mlfq_pkg::t_tstate'($urandom_range(0, 3)));
    endtask

    task automatic test_directed();
        send_item(mlfq_pkg::OP_TICK, 0, 0, mlfq_pkg::ST_WAITING);
        send_item(mlfq_pkg::OP_NOP, 31, 3, mlfq_pkg::ST_DEAD);
        send_item(mlfq_pkg::OP_ADMIT, 0, 0, mlfq_pkg::ST_READY);
        send_item(mlfq_pkg::OP_ADMIT, 31, 3, mlfq_pkg::ST_READY);
        send_item(mlfq_pkg::OP_ADMIT, 5, 1, mlfq_pkg::ST_WAITING);
        send_item(mlfq_pkg::OP_TICK, 0, 0, mlfq_pkg::ST_WAITING);
        send_item(mlfq_pkg::OP_SET_STATE, 0, 0, mlfq_pkg::ST_READY);
        send_item(mlfq_pkg::OP_TICK, 0, 0, mlfq_pkg::ST_WAITING);
        send_item(mlfq_pkg::OP_SET_STATE, 0, 0, mlfq_pkg::ST_WAITING);
        send_item(mlfq_pkg::OP_TICK, 0, 0, mlfq_pkg::ST_WAITING);
        send_item(mlfq_pkg::OP_ADMIT, 31, 2, mlfq_pkg::ST_READY);
        send_item(mlfq_pkg::OP_ADMIT, 31, 2, mlfq_pkg::ST_RUNNING);
        send_item(mlfq_pkg::OP_SET_STATE, 5, 0, mlfq_pkg::ST_READY);
        send_item(mlfq_pkg::OP_TICK, 0, 0, mlfq_pkg::ST_WAITING);
        send_item(mlfq_pkg::OP_SET_STATE, 5, 0, mlfq_pkg::ST_DEAD);
        send_item(mlfq_pkg::OP_TICK, 0, 0, mlfq_pkg::ST_WAITING);
        send_item(mlfq_pkg::OP_ADMIT, 0, 0, mlfq_pkg::ST_WAITING);
        send_item(mlfq_pkg::OP_TICK, 0, 0, mlfq_pkg::ST_WAITING);
        send_item(mlfq_pkg::OP_TICK, 0, 0, mlfq_pkg::ST_WAITING);
        send_item(mlfq_pkg::OP_ADMIT, 7, 3, mlfq_pkg::ST_DEAD);
        send_item(mlfq_pkg::OP_TICK, 0, 0, mlfq_pkg::ST_WAITING);
    endtask

    task automatic test_slice_expiry();
        set_config(1, 65535);
        for (int i = 0; i < 4; i++) send_item(mlfq_pkg::OP_ADMIT, i, 0, mlfq_pkg::ST_READY);
        repeat (40) send_item(mlfq_pkg::OP_TICK, 0, 0, mlfq_pkg::ST_WAITING);
        set_config(4095, 3);
        repeat (30) random_item(60);
    endtask

    task automatic test_boost();
        set_config(2, 1);
        repeat (250) random_item(50);
        set_config(3, 7);
        repeat (400) random_item(45);
    endtask

    task automatic test_backpressure();
        rx_idle_en = 1'b0;
        stall_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                stall_hold = 1'b0;
            end
            repeat (20) random_item(50);
        join
        rx_idle_en = 1'b1;
    endtask

    task automatic test_random();
        set_config(10, 100);
        repeat (600) random_item(40);
        set_config($urandom_range(1, 20), $urandom_range(5, 60));
        for (int i = 0; i < 600; i++) random_item(40);
    endtask

    initial begin
        shadow_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_slice_expiry();
        test_boost();
        test_backpressure();
        test_random();
        wait_drained();
        $display("Covered directed, slice expiry, boost, backpressure and random phases;");
        $display("%0d results checked.", results_seen);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (stall_hold) begin
            i_out_stall <= 1'b1;
        end else if (rx_idle_en) begin
            i_out_stall <= ($urandom_range(0, 3) == 0) ||
                           (i_out_stall && $urandom_range(0, 9) < 6);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_sched_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (sched_expected.size() == 0) begin
                report_mismatch("unexpected output transfer", 1, 0);
            end else begin
                want = sched_expected.pop_front();
                if (o_has_current !== want.has_cur)
                    report_mismatch("has_current", o_has_current, want.has_cur);
                if (o_current_thread !== want.cur_thread)
                    report_mismatch("current_thread", o_current_thread, want.cur_thread);
                if (o_current_level !== want.cur_level)
                    report_mismatch("current_level", o_current_level, want.cur_level);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
